/* rtl/fwr_pkg.sv */
package fwr_pkg;

   // grid and sample sizes
   localparam int MAX_INTERVALS = 1024;
   localparam int SAMPLE_BITS   = 24;
   localparam int CNT_BITS      = 11;
   localparam int COORD_BITS    = 10;
   localparam int WEIGHT_BITS   = 16;
   localparam int SCALE_SHIFT   = 18;

   // line store: one entry per fine column, holding rows r-2 and r-1
   localparam int LINE_DEPTH = MAX_INTERVALS + 1;
   localparam int ADDR_BITS  = $clog2(LINE_DEPTH);
   localparam int LINE_BITS  = 2 * SAMPLE_BITS;

   // stencil arithmetic: 16 times a sample fits in four more bits
   localparam int SUM_BITS  = SAMPLE_BITS + 4;
   localparam int PROD_BITS = SUM_BITS + WEIGHT_BITS + 1;
   localparam int WIN_COLS  = 3;

   // stream payload widths
   localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int OUT_FIELD_BITS = SAMPLE_BITS + 2 * COORD_BITS;
   localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

   // configuration port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = WEIGHT_BITS;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FINE_COLS = 2'd0,
      CSR_FINE_ROWS = 2'd1,
      CSR_WEIGHT    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_BORDER,
      KIND_INTERIOR,
      KIND_ERROR
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [COORD_BITS-1:0]   row;
      logic [COORD_BITS-1:0]   col;
      logic                    last;
   } meta_type;

   typedef struct packed {
      logic                    en;
      logic [ADDR_BITS-1:0]    addr;
      logic [LINE_BITS-1:0]    data;
   } line_wr_type;

endpackage

/* rtl/fwr_cell.sv */
module fwr_cell (
   input  logic                               clock,
   input  logic                               shift_en,
   input  logic                               dbl,
   input  logic signed [fwr_pkg::SUM_BITS-1:0] column_sum,
   input  logic signed [fwr_pkg::SUM_BITS-1:0] prev_sum,
   output logic signed [fwr_pkg::SUM_BITS-1:0] next_sum
);
   import fwr_pkg::*;

   logic signed [SUM_BITS-1:0] sum_ff;
   logic signed [SUM_BITS-1:0] sum_in;

   // add this column's weight to the partial handed over by the neighbor
   always_comb begin
      if (dbl) begin
         sum_in = prev_sum + (column_sum <<< 1);
      end else begin
         sum_in = prev_sum + column_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         sum_ff <= sum_in;
      end
   end

   assign next_sum = sum_ff;

endmodule

/* rtl/fwr_line_mem.sv */
module fwr_line_mem (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [fwr_pkg::ADDR_BITS-1:0]   rd_addr,
   input  fwr_pkg::line_wr_type            wr,
   output logic [fwr_pkg::LINE_BITS-1:0]   rd_data
);
   import fwr_pkg::*;

   logic [LINE_BITS-1:0] line_store [LINE_DEPTH];
   logic [LINE_BITS-1:0] rd_q_ff;
   logic                 fwd_ff;
   logic [LINE_BITS-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         line_store[wr.addr] <= wr.data;
      end
   end

   // a write to the same column in the read cycle is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff     <= line_store[rd_addr];
         fwd_ff      <= wr.en && (wr.addr == rd_addr);
         fwd_data_ff <= wr.data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_q_ff;

endmodule

/* rtl/full_weighting_restriction_unit.sv */
// Full-weighting restriction of a 2-D fine grid, streamed in row-major order at one sample
// per transfer. Program fine_cols and fine_rows (even, fine_cols at most 1024) and the Q2.14
// weight while the block is idle; each frame then takes (fine_rows+1)*(fine_cols+1) samples
// and returns the (fine_rows/2+1) by (fine_cols/2+1) coarse grid with its coordinates. Border
// points are the even fine samples themselves; an interior point is the [1 2 1;2 4 2;1 2 1]/16
// stencil scaled by the weight and saturated, and comes out with the fine sample one row below
// and one column right of its center. An odd size or fine_cols above 1024 gives a single
// result with size_error set and the rest of the frame is swallowed. The block takes one
// sample every cycle while the rsp side does not stall; the rate is set by the line store,
// a 1025 x 48-bit memory read once and written at most once per sample. A result passes
// the pipeline stages and the result register; a stalled rsp side backs up through the
// pipeline to req_tready. The line store needs no clearing after reset.
module full_weighting_restriction_unit (
   input  logic                                clock,
   input  logic                                reset,
   // fine grid samples
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [fwr_pkg::IN_DATA_BITS-1:0]    req_tdata,   // sample
   // coarse grid results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fwr_pkg::OUT_DATA_BITS-1:0]   rsp_tdata,   // value, coarse_row, coarse_col
   output logic [0:0]                          rsp_tuser,   // size_error
   output logic                                rsp_tlast,   // frame_last
   // register writes
   input  logic                                csr_we,
   input  logic [fwr_pkg::CSR_IDX_BITS-1:0]    csr_addr,
   input  logic [fwr_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import fwr_pkg::*;

   // configuration registers
   logic [CNT_BITS-1:0]    fine_cols_ff, fine_cols_in;
   logic [CNT_BITS-1:0]    fine_rows_ff, fine_rows_in;
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;

   // fine position of the next sample
   logic [CNT_BITS-1:0]    row_ff, row_in;
   logic [CNT_BITS-1:0]    col_ff, col_in;

   // pipeline stage valids and handshakes
   logic s1_vld_ff, s1_vld_in;
   logic s2_vld_ff, s2_vld_in;
   logic s3_vld_ff, s3_vld_in;
   logic s4_vld_ff, s4_vld_in;
   logic rsp_vld_ff, rsp_vld_in;
   logic accept, s1_adv, s2_adv, s3_adv, s4_adv;
   logic s2_rdy, s3_rdy, s4_rdy, out_rdy;

   // classification of the incoming sample
   logic                   size_ok, last_col, frame_end, border_hit, inner_hit;
   logic                   in_range;
   meta_type               s1_meta_in;
   logic                   s1_wr_ok_in;
   logic [ADDR_BITS-1:0]   rd_addr;

   // stage payloads
   meta_type               s1_meta_ff, s2_meta_ff, s3_meta_ff, s4_meta_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff, s2_sample_ff, s3_sample_ff, s4_sample_ff;
   logic                   s1_win_ff, s2_win_ff;
   logic                   s1_wr_ok_ff;
   logic [ADDR_BITS-1:0]   s1_addr_ff;

   // line store access and column sum
   logic [LINE_BITS-1:0]          rd_data;
   line_wr_type                   line_wr;
   logic signed [SAMPLE_BITS-1:0] up_smp, mid_smp;
   logic signed [SUM_BITS-1:0]    s2_vs_ff, s2_vs_in;

   // window chain: each cell adds one column of the stencil
   logic signed [SUM_BITS-1:0]    chain [WIN_COLS+1];
   logic                          win_shift;

   // scaling
   logic signed [WEIGHT_BITS:0]   weight_s;
   logic signed [PROD_BITS-1:0]   s4_prod_ff, s4_prod_in;
   logic signed [PROD_BITS-1:0]   scaled;
   logic [PROD_BITS-SAMPLE_BITS:0] hi_bits;
   logic signed [SAMPLE_BITS-1:0] sat_val;

   // result register
   logic [SAMPLE_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic [COORD_BITS-1:0]   rsp_row_ff, rsp_col_ff;
   logic                    rsp_err_ff, rsp_err_in;
   logic                    rsp_last_ff;

   // ---------------------------------------------------------------- configuration
   always_comb begin
      fine_cols_in = fine_cols_ff;
      fine_rows_in = fine_rows_ff;
      weight_in    = weight_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_FINE_COLS: fine_cols_in = csr_wdata[CNT_BITS-1:0];
            CSR_FINE_ROWS: fine_rows_in = csr_wdata[CNT_BITS-1:0];
            CSR_WEIGHT:    weight_in    = csr_wdata[WEIGHT_BITS-1:0];
            default:       ; // index past the register list
         endcase
      end
   end

   // ---------------------------------------------------------------- handshake chain
   assign out_rdy    = !rsp_vld_ff || rsp_tready;
   assign s4_adv     = s4_vld_ff && out_rdy;
   assign s4_rdy     = !s4_vld_ff || out_rdy;
   assign s3_adv     = s3_vld_ff && s4_rdy;
   assign s3_rdy     = !s3_vld_ff || s4_rdy;
   assign s2_adv     = s2_vld_ff && s3_rdy;
   assign s2_rdy     = !s2_vld_ff || s3_rdy;
   assign s1_adv     = s1_vld_ff && s2_rdy;
   assign req_tready = !s1_vld_ff || s2_rdy;
   assign accept     = req_tvalid && req_tready;

   assign s1_vld_in = accept || (s1_vld_ff && !s1_adv);
   assign s2_vld_in = s1_adv || (s2_vld_ff && !s2_adv);
   assign s3_vld_in = s2_adv || (s3_vld_ff && !s3_adv);
   assign s4_vld_in = s3_adv || (s4_vld_ff && !s4_adv);

   // samples that produce no result still pass through to keep the window in step
   always_comb begin
      if (out_rdy) begin
         rsp_vld_in = s4_adv && (s4_meta_ff.kind != KIND_NONE);
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   // ---------------------------------------------------------------- sample classification
   always_comb begin
      size_ok   = !fine_cols_ff[0] && !fine_rows_ff[0] &&
                  (fine_cols_ff <= CNT_BITS'(MAX_INTERVALS));
      last_col  = col_ff >= fine_cols_ff;
      frame_end = last_col && (row_ff >= fine_rows_ff);
      in_range  = col_ff <= CNT_BITS'(MAX_INTERVALS);

      border_hit = !row_ff[0] && !col_ff[0] &&
                   (row_ff == '0 || row_ff == fine_rows_ff ||
                    col_ff == '0 || col_ff == fine_cols_ff);
      inner_hit  = row_ff[0] && col_ff[0] &&
                   (row_ff >= CNT_BITS'(3)) && (row_ff < fine_rows_ff) &&
                   (col_ff >= CNT_BITS'(3)) && (col_ff < fine_cols_ff);

      // odd or centre row/col both map to the coarse index by dropping bit 0
      s1_meta_in.row  = row_ff[CNT_BITS-1:1];
      s1_meta_in.col  = col_ff[CNT_BITS-1:1];
      s1_meta_in.last = frame_end;
      priority if (!size_ok) begin
         s1_meta_in.row  = '0;
         s1_meta_in.col  = '0;
         s1_meta_in.last = 1'b1;
         s1_meta_in.kind = (row_ff == '0 && col_ff == '0) ? KIND_ERROR : KIND_NONE;
      end else if (border_hit) begin
         s1_meta_in.kind = KIND_BORDER;
      end else if (inner_hit) begin
         s1_meta_in.kind = KIND_INTERIOR;
      end else begin
         s1_meta_in.kind = KIND_NONE;
      end

      s1_wr_ok_in = size_ok && in_range;
      rd_addr     = in_range ? ADDR_BITS'(col_ff) : '0;

      // counters follow the current sizes and wrap once they reach them
      if (last_col) begin
         col_in = '0;
         row_in = (row_ff >= fine_rows_ff) ? '0 : row_ff + 1'b1;
      end else begin
         col_in = col_ff + 1'b1;
         row_in = row_ff;
      end
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fine_cols_ff <= CNT_BITS'(16);
         fine_rows_ff <= CNT_BITS'(16);
         weight_ff    <= WEIGHT_BITS'(16384);
         row_ff       <= '0;
         col_ff       <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         fine_cols_ff <= fine_cols_in;
         fine_rows_ff <= fine_rows_in;
         weight_ff    <= weight_in;
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         s3_vld_ff  <= s3_vld_in;
         s4_vld_ff  <= s4_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // ---------------------------------------------------------------- stage 1: line store read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff   <= s1_meta_in;
         s1_sample_ff <= req_tdata[SAMPLE_BITS-1:0];
         s1_win_ff    <= size_ok;
         s1_wr_ok_ff  <= s1_wr_ok_in;
         s1_addr_ff   <= rd_addr;
      end
   end

   fwr_line_mem u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .wr      (line_wr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------- stage 2: column sum
   assign up_smp  = rd_data[LINE_BITS-1 -: SAMPLE_BITS];
   assign mid_smp = rd_data[SAMPLE_BITS-1:0];

   // the column moves up one row: old middle becomes upper, new sample becomes middle
   assign line_wr.en   = s1_adv && s1_wr_ok_ff;
   assign line_wr.addr = s1_addr_ff;
   assign line_wr.data = {mid_smp, s1_sample_ff};

   // vertical [1 2 1] over rows r-2, r-1, r
   assign s2_vs_in = SUM_BITS'(up_smp) + (SUM_BITS'(mid_smp) <<< 1) + SUM_BITS'(s1_sample_ff);

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_vs_ff     <= s2_vs_in;
         s2_meta_ff   <= s1_meta_ff;
         s2_sample_ff <= s1_sample_ff;
         s2_win_ff    <= s1_win_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3: window chain
   // horizontal [1 2 1]: the last cell's register holds the full stencil sum
   assign win_shift = s2_adv && s2_win_ff;
   assign chain[0]  = '0;

   for (genvar k = 0; k < WIN_COLS; k++) begin : g_cell
      fwr_cell u_cell (
         .clock      (clock),
         .shift_en   (win_shift),
         .dbl        (1'(k == (WIN_COLS / 2))),
         .column_sum (s2_vs_ff),
         .prev_sum   (chain[k]),
         .next_sum   (chain[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s3_meta_ff   <= s2_meta_ff;
         s3_sample_ff <= s2_sample_ff;
      end
   end

   // ---------------------------------------------------------------- stage 4: weight product
   assign weight_s   = {1'b0, weight_ff};
   assign s4_prod_in = chain[WIN_COLS] * weight_s;

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         s4_prod_ff   <= s4_prod_in;
         s4_meta_ff   <= s3_meta_ff;
         s4_sample_ff <= s3_sample_ff;
      end
   end

   // ---------------------------------------------------------------- result register
   // divide by 16 and by the Q2.14 unit in one floor shift, then clamp to the sample range
   always_comb begin
      scaled  = s4_prod_ff >>> SCALE_SHIFT;
      hi_bits = scaled[PROD_BITS-1:SAMPLE_BITS-1];
      if ((&hi_bits) || !(|hi_bits)) begin
         sat_val = scaled[SAMPLE_BITS-1:0];
      end else if (scaled[PROD_BITS-1]) begin
         sat_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end

      unique case (s4_meta_ff.kind)
         KIND_BORDER:   rsp_value_in = s4_sample_ff;
         KIND_INTERIOR: rsp_value_in = sat_val;
         KIND_ERROR:    rsp_value_in = '0;
         KIND_NONE:     rsp_value_in = '0;
         default:       rsp_value_in = '0;
      endcase
      rsp_err_in = s4_meta_ff.kind == KIND_ERROR;
   end

   always_ff @(posedge clock) begin
      if (s4_adv && out_rdy) begin
         rsp_value_ff <= rsp_value_in;
         rsp_row_ff   <= s4_meta_ff.row;
         rsp_col_ff   <= s4_meta_ff.col;
         rsp_err_ff   <= rsp_err_in;
         rsp_last_ff  <= s4_meta_ff.last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(OUT_DATA_BITS-OUT_FIELD_BITS){1'b0}},
                        rsp_col_ff, rsp_row_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
